### hdl/mos_pkg.sv
// mos_pkg: shared types and constants of the masked odometer step block
// command and response transfer types, opcodes, register map constants
// no dependencies
`default_nettype none

package mos_pkg;

	localparam int UNITS_DEF      = 5;
	localparam int VALUE_BITS_DEF = 12;
	localparam int MASK_BITS_DEF  = 64;

	localparam int CFG_COUNT   = 5;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_LSB = 3;
	localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

	localparam int OUT_UNITS = 5;
	localparam int OUT_BITS  = 12;
	localparam int LOAD_BITS = 12;

	typedef enum logic [2:0] {
		OP_NEXT  = 3'd0,
		OP_BACK  = 3'd1,
		OP_FIRST = 3'd2,
		OP_LAST  = 3'd3,
		OP_LOAD  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [2:0]           unit_index;
		logic [LOAD_BITS-1:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] value_unit0;
		logic [OUT_BITS-1:0] value_unit1;
		logic [OUT_BITS-1:0] value_unit2;
		logic [OUT_BITS-1:0] value_unit3;
		logic [OUT_BITS-1:0] value_unit4;
		logic                range_error;
	} rsp_t;

	typedef struct packed {
		logic masked;
		logic has_next;
		logic has_prev;
	} unit_flags_t;

endpackage

`default_nettype wire

### hdl/mos_cfg_regs.sv
// mos_cfg_regs: apb register file holding the allowed-value masks
// depends on mos_pkg
`default_nettype none

module mos_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mos_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [mos_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [mos_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output logic      [mos_pkg::CFG_DATA_W-1:0]    masks [mos_pkg::CFG_COUNT]
);

	logic [mos_pkg::CFG_DATA_W-1:0] mask_q [mos_pkg::CFG_COUNT];
	logic [mos_pkg::CFG_IDX_W-1:0]  reg_idx;
	logic                           idx_ok;

	assign reg_idx = paddr[mos_pkg::CFG_ADDR_W-1:mos_pkg::CFG_IDX_LSB];
	assign idx_ok  = ({1'b0, reg_idx} < (mos_pkg::CFG_IDX_W + 1)'(mos_pkg::CFG_COUNT));
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mos_pkg::CFG_COUNT; i++) begin
				mask_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && idx_ok) begin
			mask_q[reg_idx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = mask_q[reg_idx];
		end
	end

	assign masks = mask_q;

endmodule

`default_nettype wire

### hdl/mos_unit_eval.sv
// mos_unit_eval: per-unit mask lookups (first, last, next and previous allowed value)
// depends on mos_pkg
`default_nettype none

module mos_unit_eval #(
	parameter int VALUE_BITS = mos_pkg::VALUE_BITS_DEF,
	parameter int MASK_BITS  = mos_pkg::MASK_BITS_DEF
) (
	input  wire logic [MASK_BITS-1:0]  mask,
	input  wire logic [VALUE_BITS-1:0] value,
	output mos_pkg::unit_flags_t       flags,
	output logic      [VALUE_BITS-1:0] first_val,
	output logic      [VALUE_BITS-1:0] last_val,
	output logic      [VALUE_BITS-1:0] next_val,
	output logic      [VALUE_BITS-1:0] prev_val
);

	logic [MASK_BITS-1:0] above;
	logic [MASK_BITS-1:0] below;

	always_comb begin
		for (int b = 0; b < MASK_BITS; b++) begin
			above[b] = mask[b] && (VALUE_BITS'(b) > value);
			below[b] = mask[b] && (VALUE_BITS'(b) < value);
		end
	end

	// priority encoders
	always_comb begin
		first_val = '0;
		next_val  = '0;
		for (int b = MASK_BITS - 1; b >= 0; b--) begin
			if (mask[b]) begin
				first_val = VALUE_BITS'(b);
			end
			if (above[b]) begin
				next_val = VALUE_BITS'(b);
			end
		end
	end

	always_comb begin
		last_val = '0;
		prev_val = '0;
		for (int b = 0; b < MASK_BITS; b++) begin
			if (mask[b]) begin
				last_val = VALUE_BITS'(b);
			end
			if (below[b]) begin
				prev_val = VALUE_BITS'(b);
			end
		end
	end

	assign flags.masked   = |mask;
	assign flags.has_next = |above;
	assign flags.has_prev = |below;

endmodule

`default_nettype wire

### hdl/mos_step_logic.sv
// mos_step_logic: one command applied to the unit chain (carry search, pivot, cascade)
// depends on mos_pkg and mos_unit_eval
`default_nettype none

module mos_step_logic #(
	parameter int UNITS      = mos_pkg::UNITS_DEF,
	parameter int VALUE_BITS = mos_pkg::VALUE_BITS_DEF,
	parameter int MASK_BITS  = mos_pkg::MASK_BITS_DEF
) (
	input  wire mos_pkg::cmd_t              cmd,
	input  wire logic [VALUE_BITS-1:0]      vals [UNITS],
	input  wire logic [mos_pkg::CFG_DATA_W-1:0] masks [mos_pkg::CFG_COUNT],
	output logic      [VALUE_BITS-1:0]      vals_nxt [UNITS],
	output logic                            range_error
);

	localparam int IDX_W = $clog2(UNITS);
	localparam int CS_W  = $clog2(UNITS + 1);
	localparam int LV_W  = ((VALUE_BITS > mos_pkg::LOAD_BITS) ? VALUE_BITS : mos_pkg::LOAD_BITS) + 1;
	localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

	mos_pkg::unit_flags_t  flags     [UNITS];
	logic [VALUE_BITS-1:0] first_val [UNITS];
	logic [VALUE_BITS-1:0] last_val  [UNITS];
	logic [VALUE_BITS-1:0] next_val  [UNITS];
	logic [VALUE_BITS-1:0] prev_val  [UNITS];

	for (genvar gi = 0; gi < UNITS; gi++) begin : g_unit
		logic [MASK_BITS-1:0] unit_mask;
		if (gi < mos_pkg::CFG_COUNT) begin : g_cfg
			assign unit_mask = masks[gi][MASK_BITS-1:0];
		end else begin : g_free
			assign unit_mask = '0;
		end
		mos_unit_eval #(
			.VALUE_BITS(VALUE_BITS),
			.MASK_BITS (MASK_BITS)
		) u_eval (
			.mask     (unit_mask),
			.value    (vals[gi]),
			.flags    (flags[gi]),
			.first_val(first_val[gi]),
			.last_val (last_val[gi]),
			.next_val (next_val[gi]),
			.prev_val (prev_val[gi])
		);
	end

	always_comb begin
		logic                  cmd_ok;
		logic                  back;
		logic                  use_last;
		logic                  hit;
		logic                  act;
		logic [IDX_W-1:0]      u;
		logic [IDX_W-1:0]      piv;
		logic [CS_W-1:0]       cs;
		logic [LV_W-1:0]       lv_ext;

		cmd_ok   = ({1'b0, cmd.unit_index} < 4'(UNITS));
		u        = cmd.unit_index[IDX_W-1:0];
		back     = (cmd.op == mos_pkg::OP_BACK);
		use_last = back || (cmd.op == mos_pkg::OP_LAST);
		lv_ext   = LV_W'(cmd.load_value);
		vals_nxt = vals;
		range_error = 1'b0;
		cs       = CS_W'(UNITS);

		// carry search: nearest unit at or above u that can take the step
		hit = 1'b0;
		piv = '0;
		for (int i = 0; i < UNITS; i++) begin
			if ((IDX_W'(i) <= u) && (!flags[i].masked ||
					(back ? flags[i].has_prev : flags[i].has_next))) begin
				hit = 1'b1;
				piv = IDX_W'(i);
			end
		end

		if (cmd_ok) begin
			case (cmd.op)
				mos_pkg::OP_NEXT, mos_pkg::OP_BACK: begin
					if (!hit || !flags[piv].masked) begin
						if (back) begin
							if (vals[piv] == '0) begin
								range_error = 1'b1;
							end else begin
								vals_nxt[piv] = vals[piv] - VALUE_BITS'(1);
							end
						end else begin
							if (vals[piv] == VMAX) begin
								range_error = 1'b1;
							end else begin
								vals_nxt[piv] = vals[piv] + VALUE_BITS'(1);
							end
						end
					end else begin
						vals_nxt[piv] = back ? prev_val[piv] : next_val[piv];
					end
					if (hit) begin
						cs = CS_W'(piv) + CS_W'(1);
					end
				end
				mos_pkg::OP_FIRST, mos_pkg::OP_LAST: begin
					cs = CS_W'(u);
				end
				mos_pkg::OP_LOAD: begin
					if (lv_ext > LV_W'(VMAX)) begin
						vals_nxt[u] = VMAX;
						range_error = 1'b1;
					end else begin
						vals_nxt[u] = VALUE_BITS'(lv_ext);
					end
				end
				default: begin
				end
			endcase
		end

		// reset cascade, stops at the first unmasked unit
		act = 1'b0;
		for (int i = 0; i < UNITS; i++) begin
			if (CS_W'(i) == cs) begin
				act = 1'b1;
			end
			if (act && flags[i].masked) begin
				vals_nxt[i] = use_last ? last_val[i] : first_val[i];
			end else begin
				act = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/masked_odometer_step.sv
// masked_odometer_step: top level, command and result registers, unit value state
// depends on mos_pkg, mos_cfg_regs and mos_step_logic
//
// A chain of time units, unit 0 the root, each with a value and an allowed-value mask
// (zero mask means any value). Each command (step next, step back, reset to first, reset
// to last, load) gives one result with all unit values after the command and a flag for
// saturation. One command is taken every clock cycle while cmd_stall is low; the command is
// registered, applied in a single combinational pass (mask priority encoders, carry search
// up the chain, reset cascade down the chain) and the result registered. A stalled result
// blocks the next command only while the command register is still occupied. Masks are
// written through the APB port at byte address 8*i for unit i and should only be changed
// while no command is in flight.
`default_nettype none

module masked_odometer_step #(
	parameter int UNITS      = mos_pkg::UNITS_DEF,
	parameter int VALUE_BITS = mos_pkg::VALUE_BITS_DEF,
	parameter int MASK_BITS  = mos_pkg::MASK_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mos_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [mos_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [mos_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire mos_pkg::cmd_t                  cmd,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output mos_pkg::rsp_t                       rsp
);

	logic [mos_pkg::CFG_DATA_W-1:0] masks [mos_pkg::CFG_COUNT];

	mos_pkg::cmd_t         cmd_s1;
	logic                  valid_s1;
	mos_pkg::rsp_t         rsp_s2;
	logic                  valid_s2;
	logic [VALUE_BITS-1:0] vals_q   [UNITS];
	logic [VALUE_BITS-1:0] vals_nxt [UNITS];
	logic                  step_err;
	logic                  s2_free;
	logic                  adv;
	logic                  cmd_take;
	logic [mos_pkg::OUT_BITS-1:0] res_vals [mos_pkg::OUT_UNITS];

	mos_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.masks  (masks)
	);

	mos_step_logic #(
		.UNITS     (UNITS),
		.VALUE_BITS(VALUE_BITS),
		.MASK_BITS (MASK_BITS)
	) u_step (
		.cmd        (cmd_s1),
		.vals       (vals_q),
		.masks      (masks),
		.vals_nxt   (vals_nxt),
		.range_error(step_err)
	);

	// transfer control
	assign s2_free   = !valid_s2 || !rsp_stall;
	assign adv       = valid_s1 && s2_free;
	assign cmd_stall = valid_s1 && !s2_free;
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < UNITS; i++) begin
				vals_q[i] <= '0;
			end
		end else begin
			if (cmd_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				vals_q   <= vals_nxt;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
		end
		if (adv) begin
			rsp_s2.value_unit0 <= res_vals[0];
			rsp_s2.value_unit1 <= res_vals[1];
			rsp_s2.value_unit2 <= res_vals[2];
			rsp_s2.value_unit3 <= res_vals[3];
			rsp_s2.value_unit4 <= res_vals[4];
			rsp_s2.range_error <= step_err;
		end
	end

	for (genvar gj = 0; gj < mos_pkg::OUT_UNITS; gj++) begin : g_out
		if (gj < UNITS) begin : g_on
			logic [VALUE_BITS+mos_pkg::OUT_BITS-1:0] wide;
			assign wide         = {{mos_pkg::OUT_BITS{1'b0}}, vals_nxt[gj]};
			assign res_vals[gj] = wide[mos_pkg::OUT_BITS-1:0];
		end else begin : g_off
			assign res_vals[gj] = '0;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire
